FILE: rtl/core/ffpa_pkg.sv
// Shared types and constants for the first-fit partition allocator.
`timescale 1ns / 1ps

package ffpa_pkg;

  localparam int unsigned CMD_W = 2;
  localparam int unsigned BLK_W = 6;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned TOT_W = 22;

  localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_REQ   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Fixed-width part of one result.
  typedef struct packed {
    logic             is_request;
    logic             granted;
    logic [BLK_W-1:0] granted_block;
    logic [TOT_W-1:0] total_leftover;
    logic [CNT_W-1:0] free_count;
  } ffpa_stat_t;

endpackage

FILE: rtl/core/ffpa_if.sv
// Valid/ready channel interfaces for allocator commands and results.
`timescale 1ns / 1ps

interface ffpa_in_if #(
  parameter int unsigned SIZE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic [ffpa_pkg::CMD_W-1:0]   cmd;
  logic [ffpa_pkg::BLK_W-1:0]   block_number;
  logic [SIZE_BITS-1:0]         size_value;

  modport source (output valid, output cmd, output block_number, output size_value,
                  input ready);
  modport sink (input valid, input cmd, input block_number, input size_value,
                output ready);
endinterface

interface ffpa_out_if #(
  parameter int unsigned SIZE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         is_request;
  logic                         granted;
  logic [ffpa_pkg::BLK_W-1:0]   granted_block;
  logic [SIZE_BITS-1:0]         granted_size;
  logic [SIZE_BITS-1:0]         leftover;
  logic [ffpa_pkg::TOT_W-1:0]   total_leftover;
  logic [ffpa_pkg::CNT_W-1:0]   free_count;

  modport source (output valid, output is_request, output granted, output granted_block,
                  output granted_size, output leftover, output total_leftover,
                  output free_count, input ready);
  modport sink (input valid, input is_request, input granted, input granted_block,
                input granted_size, input leftover, input total_leftover,
                input free_count, output ready);
endinterface

FILE: rtl/core/ffpa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module ffpa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/ffpa_oreg.sv
// Output register stage that holds one finished result until it is taken.
`timescale 1ns / 1ps

module ffpa_oreg #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          up_valid_i,
  output logic          up_ready_o,
  input  logic [DW-1:0] up_data_i,
  output logic          dn_valid_o,
  input  logic          dn_ready_i,
  output logic [DW-1:0] dn_data_o
);

  logic          valid_q;
  logic          valid_d;
  logic [DW-1:0] data_q;

  assign up_ready_o = !valid_q || dn_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (up_ready_o) begin
      valid_d = up_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_valid_i && up_ready_o) begin
      data_q <= up_data_i;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule

FILE: rtl/core/ffpa_ctrl.sv
// Sequencer that owns the size and used-flag memories and scans them first fit.
`timescale 1ns / 1ps

module ffpa_ctrl #(
  parameter int unsigned MAX_BLOCKS = 64,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [ffpa_pkg::CNT_W-1:0] block_count_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ffpa_pkg::CMD_W-1:0] cmd_i,
  input  logic [ffpa_pkg::BLK_W-1:0] blk_i,
  input  logic [SIZE_BITS-1:0]       size_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output ffpa_pkg::ffpa_stat_t       res_stat_o,
  output logic [SIZE_BITS-1:0]       res_gsize_o,
  output logic [SIZE_BITS-1:0]       res_left_o
);

  localparam int unsigned AW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW   = ((AW > ffpa_pkg::CNT_W) ? AW : ffpa_pkg::CNT_W) + 1;
  localparam int unsigned XW   = ((AW > ffpa_pkg::BLK_W) ? AW : ffpa_pkg::BLK_W) + 1;
  localparam int unsigned SUMW = ((SIZE_BITS > ffpa_pkg::TOT_W) ? SIZE_BITS
                                                                  : ffpa_pkg::TOT_W) + 1;

  ffpa_pkg::state_e state_q, state_d;

  logic [AW-1:0]                ptr_q, ptr_d;
  logic [AW-1:0]                chk_q, chk_d;
  logic                         rd_pend_q, rd_pend_d;
  logic                         issue_q, issue_d;
  logic [SIZE_BITS-1:0]         size_q, size_d;
  logic [ffpa_pkg::CNT_W-1:0]   free_q, free_d;
  logic [ffpa_pkg::TOT_W-1:0]   tot_q, tot_d;
  logic                         res_req_q, res_req_d;
  logic                         res_grant_q, res_grant_d;
  logic [ffpa_pkg::BLK_W-1:0]   res_blk_q, res_blk_d;
  logic [SIZE_BITS-1:0]         res_gsize_q, res_gsize_d;
  logic [SIZE_BITS-1:0]         res_left_q, res_left_d;

  logic                         in_fire;
  logic [CW-1:0]                bc_x, eff_x;
  logic [ffpa_pkg::CNT_W-1:0]   eff;
  logic                         ptr_last;
  logic                         chk_last;
  logic                         more;
  logic [XW-1:0]                blk_x;
  logic [XW-1:0]                chk_xw;
  logic                         blk_ok;
  logic                         hit;
  logic [SIZE_BITS-1:0]         left;
  logic [SUMW-1:0]              sum;

  logic                         size_we;
  logic [AW-1:0]                size_waddr;
  logic [SIZE_BITS-1:0]         size_rd;
  logic                         used_we;
  logic [AW-1:0]                used_waddr;
  logic                         used_wdata;
  logic                         used_rd;

  ffpa_ram #(.WIDTH(SIZE_BITS), .DEPTH(MAX_BLOCKS)) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (size_we),
    .waddr_i (size_waddr),
    .wdata_i (size_i),
    .raddr_i (ptr_q),
    .rdata_o (size_rd)
  );

  ffpa_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_waddr),
    .wdata_i (used_wdata),
    .raddr_i (ptr_q),
    .rdata_o (used_rd)
  );

  // Partition count clamped to the table depth.
  assign bc_x     = CW'(block_count_i);
  assign eff_x    = (bc_x > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : bc_x;
  assign eff      = eff_x[ffpa_pkg::CNT_W-1:0];

  assign in_ready_o = (state_q == ffpa_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign ptr_last = (ptr_q == AW'(MAX_BLOCKS - 1));
  assign chk_last = ((CW'(chk_q) + CW'(1)) == eff_x);
  assign more     = ((CW'(ptr_q) + CW'(1)) < eff_x);

  assign blk_x  = XW'(blk_i);
  assign blk_ok = (blk_x < XW'(MAX_BLOCKS));
  assign chk_xw = XW'(chk_q);

  // Read data belongs to entry chk_q, issued the cycle before.
  assign hit  = (state_q == ffpa_pkg::ST_SCAN) && rd_pend_q && !used_rd && (size_q <= size_rd);
  assign left = size_rd - size_q;
  assign sum  = SUMW'(tot_q) + SUMW'(left);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ffpa_pkg::ST_INIT: begin
        if (ptr_last) state_d = ffpa_pkg::ST_IDLE;
      end
      ffpa_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (cmd_i)
            ffpa_pkg::CMD_REQ:   state_d = (eff == '0) ? ffpa_pkg::ST_DONE : ffpa_pkg::ST_SCAN;
            ffpa_pkg::CMD_CLEAR: state_d = ffpa_pkg::ST_CLEAR;
            default:             state_d = ffpa_pkg::ST_DONE;
          endcase
        end
      end
      ffpa_pkg::ST_CLEAR: begin
        if (ptr_last) state_d = ffpa_pkg::ST_DONE;
      end
      ffpa_pkg::ST_SCAN: begin
        if (hit || (rd_pend_q && chk_last)) state_d = ffpa_pkg::ST_DONE;
      end
      ffpa_pkg::ST_DONE: begin
        if (res_ready_i) state_d = ffpa_pkg::ST_IDLE;
      end
      default: state_d = ffpa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ptr_d       = ptr_q;
    chk_d       = chk_q;
    rd_pend_d   = 1'b0;
    issue_d     = issue_q;
    size_d      = size_q;
    free_d      = free_q;
    tot_d       = tot_q;
    res_req_d   = res_req_q;
    res_grant_d = res_grant_q;
    res_blk_d   = res_blk_q;
    res_gsize_d = res_gsize_q;
    res_left_d  = res_left_q;
    size_we     = 1'b0;
    size_waddr  = blk_x[AW-1:0];
    used_we     = 1'b0;
    used_waddr  = ptr_q;
    used_wdata  = 1'b0;

    case (state_q)
      ffpa_pkg::ST_INIT, ffpa_pkg::ST_CLEAR: begin
        used_we = 1'b1;
        ptr_d   = ptr_last ? '0 : ptr_q + AW'(1);
      end
      ffpa_pkg::ST_IDLE: begin
        if (in_fire) begin
          size_d      = size_i;
          ptr_d       = '0;
          issue_d     = 1'b1;
          res_req_d   = 1'b0;
          res_grant_d = 1'b0;
          res_blk_d   = '0;
          res_gsize_d = '0;
          res_left_d  = '0;
          case (cmd_i)
            ffpa_pkg::CMD_LOAD: begin
              size_we = blk_ok;
            end
            ffpa_pkg::CMD_REQ: begin
              res_req_d = 1'b1;
            end
            ffpa_pkg::CMD_CLEAR: begin
              free_d = eff;
              tot_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ffpa_pkg::ST_SCAN: begin
        if (issue_q) begin
          rd_pend_d = 1'b1;
          chk_d     = ptr_q;
          ptr_d     = ptr_q + AW'(1);
          issue_d   = more;
        end
        if (hit) begin
          used_we     = 1'b1;
          used_waddr  = chk_q;
          used_wdata  = 1'b1;
          issue_d     = 1'b0;
          res_grant_d = 1'b1;
          res_blk_d   = chk_xw[ffpa_pkg::BLK_W-1:0];
          res_gsize_d = size_rd;
          res_left_d  = left;
          tot_d       = (sum > SUMW'(ffpa_pkg::TOT_MAX)) ? ffpa_pkg::TOT_MAX
                                                         : sum[ffpa_pkg::TOT_W-1:0];
          if (free_q != '0) free_d = free_q - ffpa_pkg::CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ffpa_pkg::ST_INIT;
      ptr_q     <= '0;
      rd_pend_q <= 1'b0;
      issue_q   <= 1'b0;
      free_q    <= '0;
      tot_q     <= '0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      rd_pend_q <= rd_pend_d;
      issue_q   <= issue_d;
      free_q    <= free_d;
      tot_q     <= tot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_q       <= chk_d;
    size_q      <= size_d;
    res_req_q   <= res_req_d;
    res_grant_q <= res_grant_d;
    res_blk_q   <= res_blk_d;
    res_gsize_q <= res_gsize_d;
    res_left_q  <= res_left_d;
  end

  assign res_valid_o                = (state_q == ffpa_pkg::ST_DONE);
  assign res_stat_o.is_request      = res_req_q;
  assign res_stat_o.granted         = res_grant_q;
  assign res_stat_o.granted_block   = res_blk_q;
  assign res_stat_o.total_leftover  = tot_q;
  assign res_stat_o.free_count      = free_q;
  assign res_gsize_o                = res_gsize_q;
  assign res_left_o                 = res_left_q;

  // A fitting entry ends the scan and the result is offered next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |=> (state_q == ffpa_pkg::ST_DONE) && res_grant_q)
    else $error("first-fit hit did not complete the request");

  // Only a request result can carry a grant.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_grant_q) |-> res_req_q)
    else $error("grant reported on a non-request result");

  // A granted leftover is the block size minus the requested size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_grant_q) |-> (res_left_q == (res_gsize_q - size_q)))
    else $error("leftover does not match granted size");

  // The fragmentation total never drops during a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffpa_pkg::ST_SCAN) |=> (tot_q >= $past(tot_q)))
    else $error("fragmentation total decreased during a scan");

endmodule

FILE: rtl/core/first_fit_partition_allocator.sv
// Top level of the first-fit fixed-partition allocator.
`timescale 1ns / 1ps

// A load, an unused command or a request with no partitions in use goes straight to its
// result; a request reads entries from zero, up to block_count clamped to MAX_BLOCKS, until
// the first fit; a clear first sweeps every used flag free. One transaction is in flight;
// the next can be accepted in the cycle after the result moves into the output register.
// Reset: used flags are swept free before the first command is accepted.

module first_fit_partition_allocator #(
  parameter int unsigned MAX_BLOCKS = 64,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ffpa_pkg::CNT_W-1:0] cfg_wdata_i,
  ffpa_in_if.sink                    in_i,
  ffpa_out_if.source                 res_o
);

  localparam int unsigned STAT_W = $bits(ffpa_pkg::ffpa_stat_t);
  localparam int unsigned DW     = STAT_W + 2 * SIZE_BITS;

  // Number of partitions in use, counted from table entry zero.
  logic [ffpa_pkg::CNT_W-1:0] block_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= '0;
    end else if (cfg_we_i) begin
      block_count_q <= cfg_wdata_i;
    end
  end

  ffpa_pkg::ffpa_stat_t   res_stat;
  ffpa_pkg::ffpa_stat_t   out_stat;
  logic [SIZE_BITS-1:0]   res_gsize;
  logic [SIZE_BITS-1:0]   res_left;
  logic                   res_valid;
  logic                   res_ready;
  logic [DW-1:0]          out_data;

  // The sequencer serializes all memory traffic, so an allocation write is
  // always finished before the next scan reads the same entry.
  ffpa_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .block_count_i (block_count_q),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .cmd_i         (in_i.cmd),
    .blk_i         (in_i.block_number),
    .size_i        (in_i.size_value),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_stat_o    (res_stat),
    .res_gsize_o   (res_gsize),
    .res_left_o    (res_left)
  );

  // The output register decouples the result consumer from the sequencer.
  ffpa_oreg #(
    .DW (DW)
  ) u_oreg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (res_valid),
    .up_ready_o (res_ready),
    .up_data_i  ({res_stat, res_gsize, res_left}),
    .dn_valid_o (res_o.valid),
    .dn_ready_i (res_o.ready),
    .dn_data_o  (out_data)
  );

  assign out_stat             = out_data[DW-1 -: STAT_W];
  assign res_o.is_request     = out_stat.is_request;
  assign res_o.granted        = out_stat.granted;
  assign res_o.granted_block  = out_stat.granted_block;
  assign res_o.total_leftover = out_stat.total_leftover;
  assign res_o.free_count     = out_stat.free_count;
  assign res_o.granted_size   = out_data[2*SIZE_BITS-1 -: SIZE_BITS];
  assign res_o.leftover       = out_data[SIZE_BITS-1:0];

endmodule
